/* rtl/tacr_pkg.sv */
// Shared types, widths, register codes and the CORDIC arctangent table
// for the tilt angle change reporter. No dependencies.
package tacr_pkg;

  // Field widths and fixed-point format
  localparam int SAMPLE_BITS  = 14;
  localparam int TIME_BITS    = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 16;
  localparam int DEG_BITS     = 8;

  // Derived datapath widths
  localparam int SQ_BITS   = 2 * SAMPLE_BITS;           // sum of two squares
  localparam int RAD_BITS  = SQ_BITS + 2 * FRAC_BITS;    // radicand of the root
  localparam int ROOT_BITS = RAD_BITS / 2;               // Q16 root
  localparam int REM_BITS  = ROOT_BITS + 2;              // root remainder
  localparam int CX_BITS   = ROOT_BITS + 4;              // rotation vector, signed
  localparam int Z_BITS    = 25;                         // angle accumulator, Q16 deg
  localparam int ZI_BITS   = Z_BITS - FRAC_BITS;         // integer degrees of |z|
  localparam int CNT_BITS  = $clog2((ROOT_BITS > CORDIC_STEPS) ? ROOT_BITS : CORDIC_STEPS);

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int THRESH_BITS   = 8;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_PERIOD    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPORT_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANGE_THRESHOLD = 2'd2;
  localparam logic [CFG_DATA_BITS-1:0] PERIOD_RESET  = 16'd100;
  localparam logic [CFG_DATA_BITS-1:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [THRESH_BITS-1:0]   THRESH_RESET  = 8'd5;

  // Result codes and fixed angles
  localparam logic ANGLE_ROLL  = 1'b0;
  localparam logic ANGLE_PITCH = 1'b1;
  localparam logic signed [DEG_BITS-1:0] DEG_RIGHT = 8'sd90;
  localparam logic signed [DEG_BITS-1:0] DEG_DIAG  = 8'sd45;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]          time_t;
  typedef logic signed [DEG_BITS-1:0]    deg_t;
  typedef logic [SQ_BITS-1:0]            sq_t;

  // One used sample on its way from front to back
  typedef struct packed {
    sample_t ax;
    sample_t ay;
    sample_t az;
    time_t   now;
  } q_item_t;

  // Status of one angle lane
  typedef struct packed {
    logic busy;
    deg_t deg;
  } angle_stat_t;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  function automatic logic signed [Z_BITS-1:0] atan_q16(input logic [CNT_BITS-1:0] i);
    logic signed [Z_BITS-1:0] v;
    case (i)
      5'd0:    v = Z_BITS'(32'sd2949120);
      5'd1:    v = Z_BITS'(32'sd1740967);
      5'd2:    v = Z_BITS'(32'sd919879);
      5'd3:    v = Z_BITS'(32'sd466945);
      5'd4:    v = Z_BITS'(32'sd234379);
      5'd5:    v = Z_BITS'(32'sd117304);
      5'd6:    v = Z_BITS'(32'sd58666);
      5'd7:    v = Z_BITS'(32'sd29335);
      5'd8:    v = Z_BITS'(32'sd14668);
      5'd9:    v = Z_BITS'(32'sd7334);
      5'd10:   v = Z_BITS'(32'sd3667);
      5'd11:   v = Z_BITS'(32'sd1833);
      5'd12:   v = Z_BITS'(32'sd917);
      5'd13:   v = Z_BITS'(32'sd458);
      5'd14:   v = Z_BITS'(32'sd229);
      5'd15:   v = Z_BITS'(32'sd115);
      5'd16:   v = Z_BITS'(32'sd57);
      5'd17:   v = Z_BITS'(32'sd29);
      5'd18:   v = Z_BITS'(32'sd14);
      5'd19:   v = Z_BITS'(32'sd7);
      5'd20:   v = Z_BITS'(32'sd4);
      5'd21:   v = Z_BITS'(32'sd2);
      5'd22:   v = Z_BITS'(32'sd1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tilt_angle_change_reporter.sv */
// Tilt angle change reporter, top level: configuration registers, front end,
// back end. Depends on tacr_pkg, tacr_front, tacr_back.
// The first report for a sample comes after the root and CORDIC lanes have run;
// special angles skip them. The back end takes one used sample at a time and
// pops the next only when its reports are out; two samples can wait in the queue,
// and samples inside the period drop at one per cycle while the queue is not full.
// Reset: synchronous, active low; registers return to 100 / 2000 / 5, state to zero.
module tilt_angle_change_reporter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tacr_pkg::sample_t                  in_accel_x,
  input  tacr_pkg::sample_t                  in_accel_y,
  input  tacr_pkg::sample_t                  in_accel_z,
  input  tacr_pkg::time_t                    in_now_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_angle_kind,
  output tacr_pkg::deg_t                     out_angle_deg,
  output logic                               out_last_report,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tacr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [tacr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  logic [tacr_pkg::CFG_DATA_BITS-1:0] period_r;
  logic [tacr_pkg::CFG_DATA_BITS-1:0] timeout_r;
  logic [tacr_pkg::THRESH_BITS-1:0]   thresh_r;
  logic                               q_valid;
  logic                               q_pop;
  tacr_pkg::q_item_t                  q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= tacr_pkg::PERIOD_RESET;
      timeout_r <= tacr_pkg::TIMEOUT_RESET;
      thresh_r  <= tacr_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tacr_pkg::CFG_SAMPLE_PERIOD:    period_r  <= cfg_data;
        tacr_pkg::CFG_REPORT_TIMEOUT:   timeout_r <= cfg_data;
        tacr_pkg::CFG_CHANGE_THRESHOLD: thresh_r  <= cfg_data[tacr_pkg::THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  tacr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_now_ms     (in_now_ms),
    .sample_period (period_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  tacr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .report_timeout   (timeout_r),
    .change_threshold (thresh_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_angle_kind   (out_angle_kind),
    .out_angle_deg    (out_angle_deg),
    .out_last_report  (out_last_report)
  );

  // A pitch report always closes its sample
  a_pitch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_angle_kind == tacr_pkg::ANGLE_PITCH) |-> out_last_report)
    else $error("pitch report not marked last");

  // Reported angles stay within a right angle
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_angle_deg) <= tacr_pkg::DEG_RIGHT &&
                   $signed(out_angle_deg) >= -tacr_pkg::DEG_RIGHT))
    else $error("reported angle out of range");

  // No result is shown right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Nothing leaves the queue unless something is in it
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

/* rtl/tacr_front.sv */
// Front end: accepts samples, drops those inside the sample period and
// queues the used ones for the back end. Depends on tacr_pkg.
module tacr_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tacr_pkg::sample_t                  in_accel_x,
  input  tacr_pkg::sample_t                  in_accel_y,
  input  tacr_pkg::sample_t                  in_accel_z,
  input  tacr_pkg::time_t                    in_now_ms,
  input  logic [tacr_pkg::CFG_DATA_BITS-1:0] sample_period,
  output logic                               q_valid,
  output tacr_pkg::q_item_t                  q_item,
  input  logic                               q_pop
);

  tacr_pkg::q_item_t                  mem_r [tacr_pkg::QUEUE_DEPTH];
  logic [tacr_pkg::QPTR_BITS-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tacr_pkg::QPTR_BITS-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tacr_pkg::QCNT_BITS-1:0]     count_r, count_nxt;
  tacr_pkg::time_t                    last_r;
  tacr_pkg::time_t                    elapsed;
  logic                               accept;
  logic                               due;
  logic                               push;
  logic                               pop;

  assign in_ready = (count_r != tacr_pkg::QCNT_BITS'(tacr_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  // Gate on time since the last used sample, modulo the time width
  assign elapsed = tacr_pkg::TIME_BITS'(in_now_ms - last_r);
  assign due     = elapsed > tacr_pkg::TIME_BITS'(sample_period);
  assign push    = accept && due;
  assign pop     = q_pop && q_valid;

  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tacr_pkg::QPTR_BITS'(tacr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == tacr_pkg::QPTR_BITS'(tacr_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      last_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (push) begin
        last_r <= in_now_ms;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{ax: in_accel_x, ay: in_accel_y, az: in_accel_z, now: in_now_ms};
    end
  end

endmodule

/* rtl/tacr_angle.sv */
// One angle lane: atan2(num, sqrt(den_sq)) in whole degrees via a
// bit-serial square root and an iterative CORDIC. Depends on tacr_pkg.
module tacr_angle (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  tacr_pkg::sample_t      num,
  input  tacr_pkg::sq_t          num_sq,
  input  tacr_pkg::sq_t          den_sq,
  output tacr_pkg::angle_stat_t  stat
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_SQRT = 2'd1;
  localparam logic [1:0] U_ROT  = 2'd2;
  localparam logic [1:0] U_FIN  = 2'd3;

  logic [1:0]                              state_r, state_nxt;
  logic [tacr_pkg::CNT_BITS-1:0]           cnt_r;
  logic [tacr_pkg::RAD_BITS-1:0]           rad_r;
  logic [tacr_pkg::REM_BITS-1:0]           rem_r;
  logic [tacr_pkg::ROOT_BITS-1:0]          root_r;
  logic signed [tacr_pkg::CX_BITS-1:0]     cx_r, cy_r;
  logic signed [tacr_pkg::Z_BITS-1:0]      z_r;
  tacr_pkg::deg_t                          deg_r;

  logic [tacr_pkg::REM_BITS-1:0]           rem_sh, trial;
  logic                                    take;
  logic [tacr_pkg::ROOT_BITS-1:0]          root_nxt;
  logic signed [tacr_pkg::CX_BITS-1:0]     dx, dy;
  logic signed [tacr_pkg::Z_BITS-1:0]      atan_w;
  logic [tacr_pkg::Z_BITS-1:0]             zmag;
  logic [tacr_pkg::ZI_BITS-1:0]            dmag;
  logic [tacr_pkg::DEG_BITS-1:0]           dlim;
  logic                                    num_neg, special;
  logic                                    sqrt_last, rot_last;

  assign stat.busy = (state_r != U_IDLE);
  assign stat.deg  = deg_r;

  // Square root step: bring down two radicand bits, try to subtract
  assign rem_sh   = {rem_r[tacr_pkg::REM_BITS-3:0], rad_r[tacr_pkg::RAD_BITS-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign take     = rem_sh >= trial;
  assign root_nxt = {root_r[tacr_pkg::ROOT_BITS-2:0], take};

  // CORDIC step
  assign dx     = cy_r >>> cnt_r;
  assign dy     = cx_r >>> cnt_r;
  assign atan_w = tacr_pkg::atan_q16(cnt_r);

  // Truncate toward zero, clamp to a right angle
  assign zmag = z_r[tacr_pkg::Z_BITS-1] ? tacr_pkg::Z_BITS'(-z_r) : tacr_pkg::Z_BITS'(z_r);
  assign dmag = zmag[tacr_pkg::Z_BITS-1:tacr_pkg::FRAC_BITS];
  assign dlim = (dmag > tacr_pkg::ZI_BITS'(tacr_pkg::DEG_RIGHT)) ?
                tacr_pkg::DEG_BITS'(tacr_pkg::DEG_RIGHT) : tacr_pkg::DEG_BITS'(dmag);

  // Zero numerator, zero denominator and the diagonal skip the iterations
  assign num_neg   = num[tacr_pkg::SAMPLE_BITS-1];
  assign special   = (num == '0) || (den_sq == '0) || (num_sq == den_sq);
  assign sqrt_last = (cnt_r == tacr_pkg::CNT_BITS'(tacr_pkg::ROOT_BITS - 1));
  assign rot_last  = (cnt_r == tacr_pkg::CNT_BITS'(tacr_pkg::CORDIC_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      U_IDLE: if (start && !special) state_nxt = U_SQRT;
      U_SQRT: if (sqrt_last) state_nxt = U_ROT;
      U_ROT:  if (rot_last) state_nxt = U_FIN;
      U_FIN:  state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      U_IDLE: begin
        if (start) begin
          rad_r  <= {den_sq, {(2 * tacr_pkg::FRAC_BITS){1'b0}}};
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
          cy_r   <= {{(tacr_pkg::CX_BITS - tacr_pkg::SAMPLE_BITS - tacr_pkg::FRAC_BITS)
                      {num_neg}}, num, {tacr_pkg::FRAC_BITS{1'b0}}};
          if (num == '0) begin
            deg_r <= '0;
          end else if (den_sq == '0) begin
            deg_r <= num_neg ? -tacr_pkg::DEG_RIGHT : tacr_pkg::DEG_RIGHT;
          end else if (num_sq == den_sq) begin
            deg_r <= num_neg ? -tacr_pkg::DEG_DIAG : tacr_pkg::DEG_DIAG;
          end
        end
      end
      U_SQRT: begin
        rem_r  <= take ? rem_sh - trial : rem_sh;
        root_r <= root_nxt;
        rad_r  <= rad_r << 2;
        if (sqrt_last) begin
          cx_r  <= tacr_pkg::CX_BITS'(root_nxt);
          z_r   <= '0;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      U_ROT: begin
        if (!cy_r[tacr_pkg::CX_BITS-1]) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          z_r  <= z_r + atan_w;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          z_r  <= z_r - atan_w;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      U_FIN: begin
        deg_r <= z_r[tacr_pkg::Z_BITS-1] ? tacr_pkg::deg_t'(-dlim) : tacr_pkg::deg_t'(dlim);
      end
      default: ;
    endcase
  end

endmodule

/* rtl/tacr_back.sv */
// Back end: squares the axes, runs the roll and pitch lanes, decides
// the reports and drives the result register. Depends on tacr_pkg, tacr_angle.
module tacr_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  tacr_pkg::q_item_t                  q_item,
  output logic                               q_pop,
  input  logic [tacr_pkg::CFG_DATA_BITS-1:0] report_timeout,
  input  logic [tacr_pkg::THRESH_BITS-1:0]   change_threshold,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_angle_kind,
  output tacr_pkg::deg_t                     out_angle_deg,
  output logic                               out_last_report
);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_SQ     = 3'd1;
  localparam logic [2:0] B_START  = 3'd2;
  localparam logic [2:0] B_WAIT   = 3'd3;
  localparam logic [2:0] B_DECIDE = 3'd4;
  localparam logic [2:0] B_EMIT_R = 3'd5;
  localparam logic [2:0] B_EMIT_P = 3'd6;

  logic [2:0]                          state_r, state_nxt;
  tacr_pkg::q_item_t                   item_r;
  tacr_pkg::sq_t                       sx_r, sy_r, sz_r;
  logic                                rep_roll_r, rep_pitch_r;
  tacr_pkg::deg_t                      prev_roll_r, prev_pitch_r;
  tacr_pkg::time_t                     roll_time_r, pitch_time_r;
  logic                                out_valid_r;
  logic                                out_kind_r;
  tacr_pkg::deg_t                      out_deg_r;
  logic                                out_last_r;

  logic signed [tacr_pkg::SQ_BITS-1:0] ax_w, ay_w, az_w;
  tacr_pkg::sq_t                       roll_den, pitch_den;
  tacr_pkg::angle_stat_t               roll_stat, pitch_stat;
  logic                                start;
  logic                                out_free;
  logic signed [tacr_pkg::DEG_BITS:0]  dr, dp;
  logic [tacr_pkg::DEG_BITS:0]         dr_abs, dp_abs;
  tacr_pkg::time_t                     roll_age, pitch_age;
  logic                                rep_roll, rep_pitch;

  // Squares of the sign-extended axes
  assign ax_w = tacr_pkg::SQ_BITS'(item_r.ax);
  assign ay_w = tacr_pkg::SQ_BITS'(item_r.ay);
  assign az_w = tacr_pkg::SQ_BITS'(item_r.az);

  assign roll_den  = tacr_pkg::SQ_BITS'(sx_r + sz_r);
  assign pitch_den = tacr_pkg::SQ_BITS'(sy_r + sz_r);
  assign start     = (state_r == B_START);

  tacr_angle u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .num    (item_r.ay),
    .num_sq (sy_r),
    .den_sq (roll_den),
    .stat   (roll_stat)
  );

  tacr_angle u_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .num    (item_r.ax),
    .num_sq (sx_r),
    .den_sq (pitch_den),
    .stat   (pitch_stat)
  );

  // Report decision: change against the previous used sample, or timeout
  assign dr     = {roll_stat.deg[tacr_pkg::DEG_BITS-1], roll_stat.deg} -
                  {prev_roll_r[tacr_pkg::DEG_BITS-1], prev_roll_r};
  assign dp     = {pitch_stat.deg[tacr_pkg::DEG_BITS-1], pitch_stat.deg} -
                  {prev_pitch_r[tacr_pkg::DEG_BITS-1], prev_pitch_r};
  assign dr_abs = dr[tacr_pkg::DEG_BITS] ? (tacr_pkg::DEG_BITS + 1)'(-dr) :
                                           (tacr_pkg::DEG_BITS + 1)'(dr);
  assign dp_abs = dp[tacr_pkg::DEG_BITS] ? (tacr_pkg::DEG_BITS + 1)'(-dp) :
                                           (tacr_pkg::DEG_BITS + 1)'(dp);
  assign roll_age  = tacr_pkg::TIME_BITS'(item_r.now - roll_time_r);
  assign pitch_age = tacr_pkg::TIME_BITS'(item_r.now - pitch_time_r);
  assign rep_roll  = (dr_abs >= (tacr_pkg::DEG_BITS + 1)'(change_threshold)) ||
                     (roll_age > tacr_pkg::TIME_BITS'(report_timeout));
  assign rep_pitch = (dp_abs >= (tacr_pkg::DEG_BITS + 1)'(change_threshold)) ||
                     (pitch_age > tacr_pkg::TIME_BITS'(report_timeout));

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == B_IDLE) && q_valid;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (q_valid) state_nxt = B_SQ;
      B_SQ:     state_nxt = B_START;
      B_START:  state_nxt = B_WAIT;
      B_WAIT:   if (!roll_stat.busy && !pitch_stat.busy) state_nxt = B_DECIDE;
      B_DECIDE: state_nxt = B_EMIT_R;
      B_EMIT_R: if (!rep_roll_r || out_free) state_nxt = B_EMIT_P;
      B_EMIT_P: if (!rep_pitch_r || out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // Control and tracked state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      prev_roll_r  <= '0;
      prev_pitch_r <= '0;
      roll_time_r  <= '0;
      pitch_time_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DECIDE) begin
        prev_roll_r  <= roll_stat.deg;
        prev_pitch_r <= pitch_stat.deg;
        if (rep_roll) begin
          roll_time_r <= item_r.now;
        end
        if (rep_pitch) begin
          pitch_time_r <= item_r.now;
        end
      end
      if ((state_r == B_EMIT_R && rep_roll_r && out_free) ||
          (state_r == B_EMIT_P && rep_pitch_r && out_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == B_SQ) begin
      sx_r <= $unsigned(ax_w * ax_w);
      sy_r <= $unsigned(ay_w * ay_w);
      sz_r <= $unsigned(az_w * az_w);
    end
    if (state_r == B_DECIDE) begin
      rep_roll_r  <= rep_roll;
      rep_pitch_r <= rep_pitch;
    end
    if (state_r == B_EMIT_R && rep_roll_r && out_free) begin
      out_kind_r <= tacr_pkg::ANGLE_ROLL;
      out_deg_r  <= prev_roll_r;
      out_last_r <= !rep_pitch_r;
    end else if (state_r == B_EMIT_P && rep_pitch_r && out_free) begin
      out_kind_r <= tacr_pkg::ANGLE_PITCH;
      out_deg_r  <= prev_pitch_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle_kind  = out_kind_r;
  assign out_angle_deg   = out_deg_r;
  assign out_last_report = out_last_r;

endmodule

/* sim/tb_top.sv */
// Self-checking bench for tilt_angle_change_reporter: clocked driver and monitor
// around a built-in roll/pitch predictor. Depends on tacr_pkg and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tacr_pkg::*;

  localparam int SETTLE_CYCLES = 256;     // covers silent samples
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_WAIT      = 10;
  localparam int AXIS_MAX      = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int AXIS_MIN      = -(2 ** (SAMPLE_BITS - 1));
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    sample_t x;
    sample_t y;
    sample_t z;
    time_t   stamp;
  } accel_sample_t;

  typedef struct {
    logic kind;
    deg_t deg;
    logic last;
  } angle_report_t;

  typedef struct {
    logic [CFG_DATA_BITS-1:0] period;
    logic [CFG_DATA_BITS-1:0] timeout;
    logic [CFG_DATA_BITS-1:0] thresh;
    int                       count;
    bit                       quiet;
  } phase_t;

  // DUT ports
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  sample_t                  in_accel_x = '0;
  sample_t                  in_accel_y = '0;
  sample_t                  in_accel_z = '0;
  time_t                    in_now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_angle_kind;
  deg_t                     out_angle_deg;
  logic                     out_last_report;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state and register copies
  logic [CFG_DATA_BITS-1:0] period_ms = PERIOD_RESET;
  logic [CFG_DATA_BITS-1:0] stale_ms = TIMEOUT_RESET;
  logic [THRESH_BITS-1:0]   thresh_deg = THRESH_RESET;
  time_t                    used_at = '0;
  time_t                    roll_sent_at = '0;
  time_t                    pitch_sent_at = '0;
  deg_t                     roll_prev = '0;
  deg_t                     pitch_prev = '0;

  // atan(2^-i) in Q16 degrees
  longint atan_deg_tab [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  accel_sample_t sample_backlog[$];
  angle_report_t due_reports[$];
  accel_sample_t cur_sample;
  int            samples_queued = 0;
  int            samples_sent = 0;
  int            report_faults = 0;
  int            send_gap = 0;
  int            recv_stall = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;
  time_t         stamp_ms = '0;
  sample_t       last_x = '0;
  sample_t       last_y = '0;
  sample_t       last_z = '0;

  tilt_angle_change_reporter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_accel_x      (in_accel_x),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_angle_kind  (out_angle_kind),
    .out_angle_deg   (out_angle_deg),
    .out_last_report (out_last_report),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // atan2(num, sqrt(den_sq)) in whole degrees: Q16 root, vectoring CORDIC
  function automatic deg_t tilt_deg(longint num, longint unsigned den_sq);
    longint unsigned rad, root, bitv;
    longint          cx, cy, acc, whole, step_x, step_y;
    int              i;
    if (num == 0) return '0;
    if (den_sq == 0) return (num > 0) ? DEG_RIGHT : -DEG_RIGHT;
    if (num * num == den_sq) return (num > 0) ? DEG_DIAG : -DEG_DIAG;
    // integer square root of den_sq * 2^32
    rad = den_sq << (2 * FRAC_BITS);
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rad) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    cx = longint'(root);
    cy = num <<< FRAC_BITS;
    acc = 0;
    // drive cy to zero, shifts floor toward minus infinity
    for (i = 0; i < CORDIC_STEPS; i++) begin
      step_x = cy >>> i;
      step_y = cx >>> i;
      if (cy >= 0) begin
        cx = cx + step_x;
        cy = cy - step_y;
        acc = acc + atan_deg_tab[i];
      end else begin
        cx = cx - step_x;
        cy = cy + step_y;
        acc = acc - atan_deg_tab[i];
      end
    end
    whole = (acc >= 0) ? (acc >>> FRAC_BITS) : -((-acc) >>> FRAC_BITS);
    if (whole > 90) whole = 90;
    if (whole < -90) whole = -90;
    return deg_t'(whole);
  endfunction

  // Update the predictor with one accepted sample, queue the reports it causes
  function automatic void track_sample(accel_sample_t s);
    time_t   since;
    longint  ax, ay, az;
    deg_t    roll, pitch;
    int      roll_move, pitch_move;
    bit      roll_due, pitch_due;
    since = s.stamp - used_at;
    if (since <= time_t'(period_ms)) return;
    ax = s.x;
    ay = s.y;
    az = s.z;
    roll = tilt_deg(ay, ax * ax + az * az);
    pitch = tilt_deg(ax, ay * ay + az * az);
    roll_move = int'(roll) - int'(roll_prev);
    if (roll_move < 0) roll_move = -roll_move;
    pitch_move = int'(pitch) - int'(pitch_prev);
    if (pitch_move < 0) pitch_move = -pitch_move;
    roll_due = (roll_move >= int'(thresh_deg)) ||
               (time_t'(s.stamp - roll_sent_at) > time_t'(stale_ms));
    pitch_due = (pitch_move >= int'(thresh_deg)) ||
                (time_t'(s.stamp - pitch_sent_at) > time_t'(stale_ms));
    if (roll_due) begin
      due_reports.push_back('{ANGLE_ROLL, roll, !pitch_due});
      roll_sent_at = s.stamp;
    end
    if (pitch_due) begin
      due_reports.push_back('{ANGLE_PITCH, pitch, 1'b1});
      pitch_sent_at = s.stamp;
    end
    used_at = s.stamp;
    roll_prev = roll;
    pitch_prev = pitch;
  endfunction

  function automatic void push_sample(int x, int y, int z, time_t stamp);
    sample_backlog.push_back('{sample_t'(x), sample_t'(y), sample_t'(z), stamp});
    samples_queued++;
  endfunction

  // Small moves around the last vector, zeros, extremes, noise near zero and full-range values
  function automatic sample_t pick_axis(sample_t prev);
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom_range(0, 1) ? sample_t'(AXIS_MAX) : sample_t'(AXIS_MIN);
      2: return sample_t'(int'($urandom_range(0, 40)) - 20);
      3, 4, 5: begin
        v = int'(prev) + int'($urandom_range(0, 600)) - 300;
        if (v > AXIS_MAX) v = AXIS_MAX;
        if (v < AXIS_MIN) v = AXIS_MIN;
        return sample_t'(v);
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void push_random(int n);
    time_t step_ms;
    repeat (n) begin
      // steady vectors exercise the no-change path
      if ($urandom_range(0, 3) != 0) begin
        last_x = pick_axis(last_x);
        last_y = pick_axis(last_y);
        last_z = pick_axis(last_z);
      end
      case ($urandom_range(0, 19))
        0: step_ms = time_t'(period_ms);
        1: step_ms = $urandom_range(0, period_ms);
        2: step_ms = $urandom;
        3: step_ms = time_t'(stale_ms) + $urandom_range(0, 3);
        4: step_ms = time_t'(period_ms) + 1;
        default: step_ms = time_t'(period_ms) + 1 + $urandom_range(0, 300);
      endcase
      stamp_ms = stamp_ms + step_ms;
      push_sample(int'(last_x), int'(last_y), int'(last_z), stamp_ms);
    end
  endfunction

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAMPLE_PERIOD:    period_ms = word;
      CFG_REPORT_TIMEOUT:   stale_ms = word;
      CFG_CHANGE_THRESHOLD: thresh_deg = word[THRESH_BITS-1:0];
      default: ;
    endcase
  endtask

  // Wait until every sample is in and every report is out, then let the pipe drain
  task automatic settle();
    while (samples_sent != samples_queued || due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sample driver
  always @(posedge clk) begin : drive_samples
    logic next_valid;
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_sample(cur_sample);
        samples_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_backlog.size() > 0) begin
          cur_sample = sample_backlog.pop_front();
          in_accel_x <= cur_sample.x;
          in_accel_y <= cur_sample.y;
          in_accel_z <= cur_sample.z;
          in_now_ms  <= cur_sample.stamp;
          next_valid = 1'b1;
          send_gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Report monitor and receiver stalls
  always @(posedge clk) begin : collect_reports
    angle_report_t want;
    logic          next_ready;
    next_ready = out_ready;
    if (!rst_n) begin
      next_ready = 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          $error("unexpected report: angle_kind %0d angle_deg %0d last_report %0d",
                 out_angle_kind, out_angle_deg, out_last_report);
          report_faults++;
        end else begin
          want = due_reports.pop_front();
          if (out_angle_kind !== want.kind) begin
            $error("angle_kind: expected %0d, got %0d", want.kind, out_angle_kind);
            report_faults++;
          end
          if (out_angle_deg !== want.deg) begin
            $error("angle_deg: expected %0d, got %0d", want.deg, out_angle_deg);
            report_faults++;
          end
          if (out_last_report !== want.last) begin
            $error("last_report: expected %0d, got %0d", want.last, out_last_report);
            report_faults++;
          end
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      next_ready = (recv_stall == 0);
    end
    out_ready <= next_ready;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    phase_t plan [6];
    plan[0] = '{16'd0, 16'd0, 16'd0, 80, 1'b0};
    plan[1] = '{16'd65535, 16'd65535, 16'h3CFF, 80, 1'b0};   // upper data bits dropped
    plan[2] = '{16'd10, 16'd500, 16'd2, 100, 1'b0};
    plan[3] = '{PERIOD_RESET, TIMEOUT_RESET, 16'(THRESH_RESET), 100, 1'b1};
    plan[4] = '{16'd1, 16'd65535, 16'd180, 100, 1'b0};
    plan[5] = '{16'd250, 16'd300, 16'd1, 90, 1'b0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: period boundary, axis extremes, right angles, diagonals, time wrap
    push_sample(0, 0, 0, 50);
    push_sample(0, 0, 0, 100);
    push_sample(0, 0, 0, 101);
    push_sample(AXIS_MAX, 0, 0, 250);
    push_sample(AXIS_MIN, 0, 0, 400);
    push_sample(0, AXIS_MAX, 0, 550);
    push_sample(0, AXIS_MIN, 0, 700);
    push_sample(0, 0, AXIS_MAX, 850);
    push_sample(0, 0, AXIS_MIN, 1000);
    push_sample(100, 100, 0, 1150);
    push_sample(-100, -100, 0, 1300);
    push_sample(100, -100, 0, 1450);
    push_sample(100, 60, 80, 1600);
    push_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1750);
    push_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN, 1900);
    push_sample(1, 0, 0, 2050);
    push_sample(-1, -1, -1, 2200);
    push_sample(1, 1, 1, 2250);
    push_sample(500, 200, -300, 32'hFFFF_FFF0);
    push_sample(510, 200, -300, 32'h0000_0060);
    push_sample(510, 200, -300, 32'h0000_0070);
    push_sample(510, 201, -300, 32'h0000_0900);
    stamp_ms = 32'h0000_0900;
    settle();

    // Random phases, each under its own register setting
    foreach (plan[p]) begin
      write_reg(CFG_SAMPLE_PERIOD, plan[p].period);
      write_reg(CFG_REPORT_TIMEOUT, plan[p].timeout);
      write_reg(CFG_CHANGE_THRESHOLD, plan[p].thresh);
      if (p == 1) write_reg(CFG_UNUSED, 16'hBEEF);
      cfg_valid <= 1'b0;
      no_idle = plan[p].quiet;
      push_random(plan[p].count);
      settle();
    end

    if (report_faults == 0 && due_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tacr_pkg.sv
rtl/tacr_front.sv
rtl/tacr_angle.sv
rtl/tacr_back.sv
rtl/tilt_angle_change_reporter.sv
sim/tb_top.sv
